// File: rtl/assert_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_IMPL(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define SFD_ASSERT_NEXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define SFD_ASSERT_IMPL(lbl, c, r, ante, cons)
`define SFD_ASSERT_NEXT(lbl, c, r, ante, cons)
`endif
`endif

// File: rtl/sfd_pkg.sv
// Types, constants and helpers of the shake and face-down detector.
package sfd_pkg;

    localparam int ACCEL_FRAC_BITS_DEF = 12;
    localparam int BASE_EXTRA_BITS     = 12;
    localparam int ACCEL_W             = 16;
    localparam int ABS_W               = ACCEL_W + 1;
    localparam int PROD_W              = 31;
    localparam int SUM_W               = 34;
    localparam int MAG_W               = 16;
    localparam int ROOT_W              = 17;
    localparam int REM_W               = 20;
    localparam int BASE_W              = 32;
    localparam int MAGX_W              = MAG_W + BASE_EXTRA_BITS;
    localparam int NUM_W               = 37;
    localparam int DIV_W               = 36;
    localparam int TIME_W              = 32;
    localparam int CFG_W               = 16;
    localparam int CFG_IDX_W           = 3;
    localparam int FIFO_DEPTH          = 2;
    localparam int SQRT_STEPS          = 17;
    localparam int DIV_DIGITS          = 9;
    localparam int STEP_W              = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAKE_THRESHOLD = 3'd0,
        CFG_SHAKE_HOLD_MS   = 3'd1,
        CFG_FACE_Z_LIMIT    = 3'd2,
        CFG_FACE_XY_LIMIT   = 3'd3,
        CFG_COUNT_CEILING   = 3'd4,
        CFG_COUNT_FLOOR     = 3'd5,
        CFG_ENTER_LEVEL     = 3'd6,
        CFG_LEAVE_LEVEL     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] shake_threshold;
        logic        [15:0] shake_hold_ms;
        logic signed [15:0] face_z_limit;
        logic        [14:0] face_xy_limit;
        logic        [6:0]  count_ceiling;
        logic signed [7:0]  count_floor;
        logic signed [7:0]  enter_level;
        logic signed [7:0]  leave_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        shake_threshold: 16'd3277,
        shake_hold_ms:   16'd800,
        face_z_limit:    -16'sd2867,
        face_xy_limit:   15'd1638,
        count_ceiling:   7'd20,
        count_floor:     -8'sd10,
        enter_level:     8'sd15,
        leave_level:     -8'sd8
    };

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] time_ms;
        logic              down;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ACC,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQRT,
        B_UPDATE,
        B_DIV
    } back_state_t;

    typedef struct packed {
        logic [3:0] q;
        logic [2:0] r;
    } div5_t;

    // one radix-16 digit of a divide by five; val < 80
    function automatic div5_t div5_step(input logic [6:0] val);
        logic [14:0] prod;
        logic [6:0]  qx5;
        logic [6:0]  rem;
        div5_t       d;
        prod = {8'b0, val} * 15'd205;
        d.q  = prod[13:10];
        qx5  = {1'b0, d.q, 2'b00} + {3'b000, d.q};
        rem  = val - qx5;
        d.r  = rem[2:0];
        return d;
    endfunction

endpackage

// File: rtl/sfd_if.sv
// Sample and result channel interfaces of the detector.
interface sfd_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfd_pkg::ACCEL_W-1:0]  accel_x;
    logic signed [sfd_pkg::ACCEL_W-1:0]  accel_y;
    logic signed [sfd_pkg::ACCEL_W-1:0]  accel_z;
    logic        [sfd_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output time_ms, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input time_ms, output ready);
endinterface

interface sfd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       shake_active;
    logic                       face_down_active;
    logic [sfd_pkg::MAG_W-1:0]  magnitude;

    modport source (output valid, output shake_active, output face_down_active,
                    output magnitude, input ready);
    modport sink   (input valid, input shake_active, input face_down_active,
                    input magnitude, output ready);
endinterface

// File: rtl/sfd_front.sv
// Front end: accepts samples, classifies face-down and sums the squared axes.
`include "assert_macros.svh"

module sfd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    sfd_sample_if.sink            sample,
    input  sfd_pkg::cfg_t         cfg,
    input  sfd_pkg::fifo_status_t fifo_status,
    output logic                  push,
    output sfd_pkg::sample_t      push_data
);

    sfd_pkg::front_state_t state_reg, state_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [sfd_pkg::ABS_W-1:0]    ax_reg, ay_reg, az_reg;
    logic [sfd_pkg::ABS_W-1:0]    ax_in, ay_in, az_in;
    logic [sfd_pkg::TIME_W-1:0]   time_reg;
    logic                         down_reg;
    logic                         down_in;
    logic [sfd_pkg::PROD_W-1:0]   prod_reg;
    logic [sfd_pkg::SUM_W-1:0]    sum_reg;
    logic [sfd_pkg::ABS_W-1:0]    mul_op;
    logic [2*sfd_pkg::ABS_W-1:0]  mul_full;
    logic                         accept;
    logic                         mul_en;
    logic                         acc_en;

    assign ax_in = sample.accel_x[sfd_pkg::ACCEL_W-1]
                 ? sfd_pkg::ABS_W'(0) - {sample.accel_x[sfd_pkg::ACCEL_W-1], sample.accel_x}
                 : {1'b0, sample.accel_x};
    assign ay_in = sample.accel_y[sfd_pkg::ACCEL_W-1]
                 ? sfd_pkg::ABS_W'(0) - {sample.accel_y[sfd_pkg::ACCEL_W-1], sample.accel_y}
                 : {1'b0, sample.accel_y};
    assign az_in = sample.accel_z[sfd_pkg::ACCEL_W-1]
                 ? sfd_pkg::ABS_W'(0) - {sample.accel_z[sfd_pkg::ACCEL_W-1], sample.accel_z}
                 : {1'b0, sample.accel_z};

    assign down_in = (sample.accel_z < cfg.face_z_limit)
                  && (ax_in < {2'b00, cfg.face_xy_limit})
                  && (ay_in < {2'b00, cfg.face_xy_limit});

    always_comb
    begin
        case (cnt_reg)
            2'd0:    mul_op = ax_reg;
            2'd1:    mul_op = ay_reg;
            default: mul_op = az_reg;
        endcase
    end

    assign mul_full = mul_op * mul_op;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::F_IDLE:
            begin
                if (sample.valid)
                    state_next = sfd_pkg::F_MUL;
            end
            sfd_pkg::F_MUL:
            begin
                if (cnt_reg == 2'd2)
                    state_next = sfd_pkg::F_ACC;
            end
            sfd_pkg::F_ACC:
            begin
                state_next = sfd_pkg::F_PUSH;
            end
            sfd_pkg::F_PUSH:
            begin
                if (!fifo_status.full)
                    state_next = sfd_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample.ready = 1'b0;
        mul_en       = 1'b0;
        acc_en       = 1'b0;
        push         = 1'b0;
        unique case (state_reg)
            sfd_pkg::F_IDLE:  sample.ready = 1'b1;
            sfd_pkg::F_MUL:   mul_en       = 1'b1;
            sfd_pkg::F_ACC:   acc_en       = 1'b1;
            sfd_pkg::F_PUSH:  push         = !fifo_status.full;
        endcase
    end

    assign accept   = sample.valid && sample.ready;
    assign cnt_next = accept ? 2'd0 : (mul_en ? cnt_reg + 2'd1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfd_pkg::F_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg   <= ax_in;
            ay_reg   <= ay_in;
            az_reg   <= az_in;
            time_reg <= sample.time_ms;
            down_reg <= down_in;
            prod_reg <= '0;
            sum_reg  <= '0;
        end
        else if (mul_en)
        begin
            prod_reg <= mul_full[sfd_pkg::PROD_W-1:0];
            sum_reg  <= sum_reg + {3'b000, prod_reg};
        end
        else if (acc_en)
        begin
            sum_reg  <= sum_reg + {3'b000, prod_reg};
        end
    end

    assign push_data = '{sum: sum_reg, time_ms: time_reg, down: down_reg};

    `SFD_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, accept, (state_reg == sfd_pkg::F_MUL) && (cnt_reg == 2'd0))

endmodule

// File: rtl/sfd_fifo.sv
// Short queue of summed samples between front and back end.
`include "assert_macros.svh"

module sfd_fifo #(
    parameter int DEPTH = sfd_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sfd_pkg::sample_t      push_data,
    input  logic                  pop,
    output sfd_pkg::sample_t      pop_data,
    output sfd_pkg::fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::sample_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    `SFD_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !status.full)
    `SFD_ASSERT_IMPL(a_no_pop_when_empty, clk, rst_n, pop, !status.empty)

endmodule

// File: rtl/sfd_back.sv
// Back end: square root, shake and face-down state update, baseline filter.
`include "assert_macros.svh"

module sfd_back #(
    parameter int ACCEL_FRAC_BITS = sfd_pkg::ACCEL_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfd_pkg::cfg_t         cfg,
    input  sfd_pkg::fifo_status_t fifo_status,
    input  sfd_pkg::sample_t      pop_data,
    output logic                  pop,
    sfd_result_if.source          result
);

    localparam logic [sfd_pkg::BASE_W-1:0] BASE_RESET =
        sfd_pkg::BASE_W'(1) << (ACCEL_FRAC_BITS + sfd_pkg::BASE_EXTRA_BITS);

    sfd_pkg::back_state_t state_reg, state_next;
    logic [sfd_pkg::STEP_W-1:0]  step_reg;
    logic [sfd_pkg::SUM_W-1:0]   rad_reg;
    logic [sfd_pkg::REM_W-1:0]   rem_reg;
    logic [sfd_pkg::ROOT_W-1:0]  root_reg;
    logic [sfd_pkg::TIME_W-1:0]  time_reg;
    logic                        down_reg;
    logic [sfd_pkg::BASE_W-1:0]  baseline_reg;
    logic [sfd_pkg::TIME_W-1:0]  last_time_reg;
    logic                        shake_reg, shake_next;
    logic signed [7:0]           face_count_reg, face_count_next;
    logic                        face_reg, face_next;
    logic [sfd_pkg::DIV_W-1:0]   div_reg;
    logic [2:0]                  div_rem_reg;
    logic                        out_valid_reg;
    logic                        out_shake_reg;
    logic                        out_face_reg;
    logic [sfd_pkg::MAG_W-1:0]   out_mag_reg;

    logic                        out_free;
    logic                        sqrt_en, update_en, div_en;
    logic                        last_step;
    logic [sfd_pkg::REM_W-1:0]   rem_shift, trial;
    logic                        root_bit;
    logic [sfd_pkg::MAG_W-1:0]   mag;
    logic [sfd_pkg::MAGX_W-1:0]  magx;
    logic [32:0]                 dev, dev_abs, thr_x;
    logic                        dev_over;
    logic [sfd_pkg::TIME_W-1:0]  elapsed;
    logic signed [7:0]           ceil_s;
    logic [sfd_pkg::NUM_W-1:0]   base_ext, num;
    sfd_pkg::div5_t              digit;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::B_IDLE:
            begin
                if (!fifo_status.empty)
                    state_next = sfd_pkg::B_SQRT;
            end
            sfd_pkg::B_SQRT:
            begin
                if (last_step)
                    state_next = sfd_pkg::B_UPDATE;
            end
            sfd_pkg::B_UPDATE:
            begin
                if (out_free)
                    state_next = sfd_pkg::B_DIV;
            end
            sfd_pkg::B_DIV:
            begin
                if (last_step)
                    state_next = sfd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        sqrt_en   = 1'b0;
        update_en = 1'b0;
        div_en    = 1'b0;
        last_step = 1'b0;
        unique case (state_reg)
            sfd_pkg::B_IDLE:   pop       = !fifo_status.empty;
            sfd_pkg::B_SQRT:
            begin
                sqrt_en   = 1'b1;
                last_step = (step_reg == sfd_pkg::STEP_W'(sfd_pkg::SQRT_STEPS - 1));
            end
            sfd_pkg::B_UPDATE: update_en = out_free;
            sfd_pkg::B_DIV:
            begin
                div_en    = 1'b1;
                last_step = (step_reg == sfd_pkg::STEP_W'(sfd_pkg::DIV_DIGITS - 1));
            end
        endcase
    end

    // square root, one result bit per step
    assign rem_shift = {rem_reg[sfd_pkg::REM_W-3:0], rad_reg[sfd_pkg::SUM_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_bit  = (rem_shift >= trial);

    // shake decision
    assign mag      = root_reg[sfd_pkg::MAG_W-1:0];
    assign magx     = {mag, sfd_pkg::BASE_EXTRA_BITS'(0)};
    assign dev      = {5'b0, magx} - {1'b0, baseline_reg};
    assign dev_abs  = dev[32] ? 33'd0 - dev : dev;
    assign thr_x    = {5'b0, cfg.shake_threshold, sfd_pkg::BASE_EXTRA_BITS'(0)};
    assign dev_over = (dev_abs > thr_x);
    assign elapsed  = time_reg - last_time_reg;

    always_comb
    begin
        shake_next = shake_reg;
        if (dev_over)
            shake_next = 1'b1;
        else if (elapsed > {16'b0, cfg.shake_hold_ms})
            shake_next = 1'b0;
    end

    // face-down counter and hysteresis
    assign ceil_s = signed'({1'b0, cfg.count_ceiling});

    always_comb
    begin
        face_count_next = face_count_reg;
        if (down_reg)
        begin
            if (face_count_reg < ceil_s)
                face_count_next = face_count_reg + 8'sd1;
        end
        else if (face_count_reg > cfg.count_floor)
        begin
            face_count_next = face_count_reg - 8'sd1;
        end
        face_next = face_reg;
        if (!face_reg && (face_count_next >= cfg.enter_level))
            face_next = 1'b1;
        else if (face_reg && (face_count_next <= cfg.leave_level))
            face_next = 1'b0;
    end

    // 19 * baseline + new magnitude, divided by 20 as a shift and radix-16 divide by 5
    assign base_ext = {5'b0, baseline_reg};
    assign num      = (base_ext << 4) + (base_ext << 1) + base_ext + {9'b0, magx};
    assign digit    = sfd_pkg::div5_step({div_rem_reg, div_reg[sfd_pkg::DIV_W-1 -: 4]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sfd_pkg::B_IDLE;
            step_reg       <= '0;
            baseline_reg   <= BASE_RESET;
            last_time_reg  <= '0;
            shake_reg      <= 1'b0;
            face_count_reg <= '0;
            face_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop || update_en || last_step)
                step_reg <= '0;
            else if (sqrt_en || div_en)
                step_reg <= step_reg + sfd_pkg::STEP_W'(1);
            if (update_en)
            begin
                shake_reg      <= shake_next;
                face_count_reg <= face_count_next;
                face_reg       <= face_next;
                if (dev_over)
                    last_time_reg <= time_reg;
            end
            if (div_en && last_step)
                baseline_reg <= {div_reg[27:0], digit.q};
            if (update_en)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rad_reg  <= pop_data.sum;
            rem_reg  <= '0;
            root_reg <= '0;
            time_reg <= pop_data.time_ms;
            down_reg <= pop_data.down;
        end
        else if (sqrt_en)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= root_bit ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[sfd_pkg::ROOT_W-2:0], root_bit};
        end
        if (update_en)
        begin
            div_reg       <= {1'b0, num[sfd_pkg::NUM_W-1:2]};
            div_rem_reg   <= 3'd0;
            out_shake_reg <= shake_next;
            out_face_reg  <= face_next;
            out_mag_reg   <= mag;
        end
        else if (div_en)
        begin
            div_reg     <= {div_reg[sfd_pkg::DIV_W-5:0], digit.q};
            div_rem_reg <= digit.r;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.shake_active     = out_shake_reg;
    assign result.face_down_active = out_face_reg;
    assign result.magnitude        = out_mag_reg;

    `SFD_ASSERT_NEXT(a_update_fills_output, clk, rst_n, update_en, out_valid_reg)

endmodule

// File: rtl/shake_and_face_down_detector.sv
// An accepted sample passes the front end, the queue and the back end in turn.
// The back end sets the pace: it works on one word at a time, through its 17-step
// square root and 9-digit divide by 20 of the baseline filter, and waits while its
// result word is not taken; the front end runs ahead by up to FIFO_DEPTH words.
// Reset: asynchronous, active low; clears control, flags, counter, baseline to 1 g
// and all configuration registers to their defaults.
module shake_and_face_down_detector #(
    parameter int ACCEL_FRAC_BITS = sfd_pkg::ACCEL_FRAC_BITS_DEF,
    parameter int FIFO_DEPTH      = sfd_pkg::FIFO_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sfd_sample_if.sink                      sample,
    sfd_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::CFG_W-1:0]       cfg_wdata
);

    sfd_pkg::cfg_t         cfg_reg;
    sfd_pkg::fifo_status_t fifo_status;
    sfd_pkg::sample_t      push_data, pop_data;
    logic                  push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sfd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sfd_pkg::cfg_index_t'(cfg_index))
                sfd_pkg::CFG_SHAKE_THRESHOLD:
                    cfg_reg.shake_threshold <= cfg_wdata;
                sfd_pkg::CFG_SHAKE_HOLD_MS:
                    cfg_reg.shake_hold_ms   <= cfg_wdata;
                sfd_pkg::CFG_FACE_Z_LIMIT:
                    cfg_reg.face_z_limit    <= signed'(cfg_wdata);
                sfd_pkg::CFG_FACE_XY_LIMIT:
                    cfg_reg.face_xy_limit   <= cfg_wdata[14:0];
                sfd_pkg::CFG_COUNT_CEILING:
                    cfg_reg.count_ceiling   <= cfg_wdata[6:0];
                sfd_pkg::CFG_COUNT_FLOOR:
                    cfg_reg.count_floor     <= signed'(cfg_wdata[7:0]);
                sfd_pkg::CFG_ENTER_LEVEL:
                    cfg_reg.enter_level     <= signed'(cfg_wdata[7:0]);
                sfd_pkg::CFG_LEAVE_LEVEL:
                    cfg_reg.leave_level     <= signed'(cfg_wdata[7:0]);
            endcase
        end
    end

    sfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .push        (push),
        .push_data   (push_data)
    );

    sfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_status)
    );

    sfd_back #(
        .ACCEL_FRAC_BITS (ACCEL_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .result      (result)
    );

endmodule

// File: test/tb_shake_and_face_down_detector.sv
`timescale 1ns / 1ps
// Testbench of the shake and face-down detector: directed table and random samples.
module tb_shake_and_face_down_detector;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic        [31:0] t;
    } accel_word_t;

    typedef struct packed {
        logic        shake;
        logic        face;
        logic [15:0] mag;
    } detect_word_t;

    typedef struct packed {
        accel_word_t  sample;
        logic         known;
        detect_word_t want;
    } probe_row_t;

    typedef enum logic [1:0] {
        M_FACE_DOWN,
        M_REST,
        M_SHAKE,
        M_NOISE
    } motion_t;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int NUM_PROBES      = 22;

    localparam logic [15:0] SPARE_BITS [8] = '{16'h0000, 16'h0000, 16'h0000, 16'h8000,
                                               16'hFF80, 16'hFF00, 16'hFF00, 16'hFF00};

    localparam probe_row_t PROBES [NUM_PROBES] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 32'h0000_0000}, 1'b1, '{1'b1, 1'b0, 16'd0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, 32'h0000_0001}, 1'b1,
          '{1'b1, 1'b0, 16'd56755}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 32'h0000_0002}, 1'b0, '0},
        '{'{-16'sd32768, 16'sd0, 16'sd0, 32'h0000_0003}, 1'b0, '0},
        '{'{16'sd0, -16'sd32768, 16'sd0, 32'h0000_0004}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd2867, 32'h0000_0005}, 1'b0, '0},
        '{'{16'sd1638, 16'sd0, -16'sd4096, 32'h0000_0006}, 1'b0, '0},
        '{'{16'sd1637, -16'sd1637, -16'sd2868, 32'h0000_0007}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'hFFFF_FFC0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'hFFFF_FFE8}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0010}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0038}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0060}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0088}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_00B0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_00D8}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0100}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0128}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0150}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_0178}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_01A0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd4096, 32'h0000_01C8}, 1'b0, '0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfd_pkg::CFG_W-1:0]     cfg_wdata;

    sfd_sample_if sample_ch();
    sfd_result_if result_ch();

    shake_and_face_down_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sfd_pkg::cfg_t cfg_model      = sfd_pkg::CFG_RESET;
    logic [31:0]   baseline_q     = 32'h1 << (sfd_pkg::ACCEL_FRAC_BITS_DEF
                                              + sfd_pkg::BASE_EXTRA_BITS);
    logic [31:0]   last_shake_q   = '0;
    logic          shake_q        = 1'b0;
    int            face_count_q   = 0;
    logic          face_q         = 1'b0;

    detect_word_t detections_due [$];
    int           samples_sent    = 0;
    int           words_checked   = 0;
    int           mismatch_count  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [15:0] root_floor(longint unsigned n);
        longint unsigned acc;
        longint unsigned probe;
        acc   = 0;
        probe = 64'h1 << 34;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= acc + probe)
            begin
                n   -= acc + probe;
                acc  = (acc >> 1) + probe;
            end
            else
            begin
                acc >>= 1;
            end
            probe >>= 2;
        end
        return acc[15:0];
    endfunction

    function automatic detect_word_t compute_detection(accel_word_t s);
        longint      xl, yl, zl;
        longint      magx, dev;
        logic [31:0] elapsed;
        int          ax, ay;
        bit          flat_down;
        detect_word_t w;
        xl = longint'(s.x);
        yl = longint'(s.y);
        zl = longint'(s.z);
        w.mag = root_floor(longint'(xl * xl + yl * yl + zl * zl));

        magx = longint'(w.mag) << sfd_pkg::BASE_EXTRA_BITS;
        dev  = magx - longint'(baseline_q);
        if (dev < 0)
            dev = -dev;
        elapsed = s.t - last_shake_q;
        if (dev > (longint'(cfg_model.shake_threshold) << sfd_pkg::BASE_EXTRA_BITS))
        begin
            shake_q      = 1'b1;
            last_shake_q = s.t;
        end
        else if (elapsed > 32'(cfg_model.shake_hold_ms))
        begin
            shake_q = 1'b0;
        end
        baseline_q = 32'((longint'(baseline_q) * 19 + magx) / 20);

        ax = (s.x < 0) ? -int'(s.x) : int'(s.x);
        ay = (s.y < 0) ? -int'(s.y) : int'(s.y);
        flat_down = (s.z < $signed(cfg_model.face_z_limit))
                 && (ax < int'(cfg_model.face_xy_limit))
                 && (ay < int'(cfg_model.face_xy_limit));
        if (flat_down)
        begin
            if (face_count_q < int'(cfg_model.count_ceiling))
                face_count_q++;
        end
        else if (face_count_q > int'($signed(cfg_model.count_floor)))
        begin
            face_count_q--;
        end
        if (!face_q && face_count_q >= int'($signed(cfg_model.enter_level)))
            face_q = 1'b1;
        else if (face_q && face_count_q <= int'($signed(cfg_model.leave_level)))
            face_q = 1'b0;

        w.shake = shake_q;
        w.face  = face_q;
        return w;
    endfunction

    function automatic logic signed [15:0] clamp_axis(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic accel_word_t draw_motion(motion_t mode);
        accel_word_t s;
        int          lim;
        int          zlim;
        lim  = int'(cfg_model.face_xy_limit) + 64;
        zlim = int'($signed(cfg_model.face_z_limit));
        s    = '0;
        case (mode)
            M_FACE_DOWN:
            begin
                s.x = clamp_axis(int'($urandom_range(0, 2 * lim)) - lim);
                s.y = clamp_axis(int'($urandom_range(0, 2 * lim)) - lim);
                s.z = clamp_axis(zlim + 200 - int'($urandom_range(0, 1500)));
            end
            M_REST:
            begin
                s.x = clamp_axis(int'($urandom_range(0, 600)) - 300);
                s.y = clamp_axis(int'($urandom_range(0, 600)) - 300);
                s.z = clamp_axis(4096 + int'($urandom_range(0, 600)) - 300);
            end
            M_SHAKE:
            begin
                s.x = clamp_axis(int'($urandom_range(0, 40000)) - 20000);
                s.y = clamp_axis(int'($urandom_range(0, 40000)) - 20000);
                s.z = clamp_axis(int'($urandom_range(0, 40000)) - 20000);
            end
            default:
            begin
                s.x = 16'($urandom);
                s.y = 16'($urandom);
                s.z = 16'($urandom);
                if ($urandom_range(3) == 0)
                    s.x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                if ($urandom_range(3) == 0)
                    s.z = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            end
        endcase
        return s;
    endfunction

    task automatic offer(input accel_word_t s, input logic known, input detect_word_t typed);
        detect_word_t calc;
        while (!(samples_sent >= 200 && samples_sent < 260) && $urandom_range(99) < 30)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= s.x;
        sample_ch.accel_y <= s.y;
        sample_ch.accel_z <= s.z;
        sample_ch.time_ms <= s.t;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        calc = compute_detection(s);
        detections_due.push_back(known ? typed : calc);
        samples_sent++;
    endtask

    task automatic settle();
        while (detections_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] vals [8]);
        logic [15:0] v;
        for (int i = 0; i < 8; i++)
        begin
            v = vals[i] | (16'($urandom) & SPARE_BITS[i]);
            cfg_we    <= 1'b1;
            cfg_index <= sfd_pkg::cfg_index_t'(i);
            cfg_wdata <= v;
            @(posedge clk);
            case (sfd_pkg::cfg_index_t'(i))
                sfd_pkg::CFG_SHAKE_THRESHOLD: cfg_model.shake_threshold = v;
                sfd_pkg::CFG_SHAKE_HOLD_MS:   cfg_model.shake_hold_ms   = v;
                sfd_pkg::CFG_FACE_Z_LIMIT:    cfg_model.face_z_limit    = v;
                sfd_pkg::CFG_FACE_XY_LIMIT:   cfg_model.face_xy_limit   = v[14:0];
                sfd_pkg::CFG_COUNT_CEILING:   cfg_model.count_ceiling   = v[6:0];
                sfd_pkg::CFG_COUNT_FLOOR:     cfg_model.count_floor     = v[7:0];
                sfd_pkg::CFG_ENTER_LEVEL:     cfg_model.enter_level     = v[7:0];
                sfd_pkg::CFG_LEAVE_LEVEL:     cfg_model.leave_level     = v[7:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    initial begin : result_sink
        int           hold_left;
        bit           held_once;
        detect_word_t got;
        detect_word_t want;
        hold_left = 0;
        held_once = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.shake_active, result_ch.face_down_active,
                        result_ch.magnitude};
                if (detections_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: word with none pending: shake=%0b face=%0b mag=%0d",
                             $time, got.shake, got.face, got.mag);
                end
                else
                begin
                    want = detections_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display({"%0t: expected shake=%0b face=%0b mag=%0d,",
                                  " actual shake=%0b face=%0b mag=%0d"},
                                 $time, want.shake, want.face, want.mag,
                                 got.shake, got.face, got.mag);
                    end
                end
                words_checked++;
            end
            if (!held_once && words_checked == 50)
            begin
                held_once = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (words_checked >= 280 && words_checked < 340)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    initial begin : stimulus
        accel_word_t s;
        motion_t     mode;
        logic [31:0] now;
        logic [15:0] vals [8];
        int          r;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= sfd_pkg::CFG_SHAKE_THRESHOLD;
        cfg_wdata         <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        sample_ch.time_ms <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
            offer(PROBES[i].sample, PROBES[i].known, PROBES[i].want);

        now  = 32'h0000_0400;
        mode = M_REST;
        for (int p = 1; p <= PHASES; p++)
        begin
            sample_ch.valid <= 1'b0;
            settle();
            case (p)
                1: vals = '{16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'h0080, 16'h0080, 16'h0080};
                2: vals = '{16'hFFFF, 16'hFFFF, 16'd0, 16'h7FFF, 16'd127, 16'd0, 16'd127,
                            16'd127};
                3: vals = '{16'd2000, 16'd300, 16'hF830, 16'd3000, 16'd5, 16'd40, 16'd3, 16'd2};
                4: vals = '{16'($urandom), 16'($urandom), 16'h8000, 16'd0, 16'd127, 16'h0080,
                            16'($urandom), 16'($urandom)};
                7: vals = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
                default:
                    vals = '{16'($urandom_range(200, 6000)), 16'($urandom_range(0, 1500)),
                             16'(-int'($urandom_range(500, 4000))),
                             16'($urandom_range(300, 4000)), 16'($urandom_range(0, 40)),
                             16'(-int'($urandom_range(0, 40))),
                             16'(int'($urandom_range(0, 60)) - 30),
                             16'(int'($urandom_range(0, 60)) - 30)};
            endcase
            load_settings(vals);
            if (p == 2 || p == 5)
                now = 32'hFFFF_FFFF - $urandom_range(0, 3000);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                begin
                    sample_ch.valid <= 1'b0;
                    settle();
                end
                r = $urandom_range(99);
                if (r < 8)
                begin
                    r = $urandom_range(99);
                    mode = (r < 40) ? M_FACE_DOWN : (r < 70) ? M_REST :
                           (r < 90) ? M_SHAKE : M_NOISE;
                end
                r = $urandom_range(99);
                if (r < 3)
                    now = $urandom;
                else if (r < 12)
                    now += $urandom_range(500, 3000);
                else if (r >= 15)
                    now += $urandom_range(10, 40);
                s   = draw_motion(mode);
                s.t = now;
                offer(s, 1'b0, '0);
            end
        end

        sample_ch.valid <= 1'b0;
        settle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
